[src/adf_pkg.sv]
// Package for the application message deframer.
// Holds the event codes, raw message type codes, header constants and the result type.
// No dependencies.
package adf_pkg;

    localparam int unsigned HDR_BYTES = 12;
    localparam int unsigned HDR_CNT_W = 4;

    localparam logic [7:0]  APPDU_VERSION   = 8'h00;
    localparam logic [15:0] ID_PAYLOAD_LEN  = 16'd8;
    localparam logic [15:0] MAX_LEN_DEFAULT = 16'd1500;

    // raw message type codes as they appear in header byte 1
    localparam logic [7:0] TYPE_NOP       = 8'h00;
    localparam logic [7:0] TYPE_ID_REQ    = 8'h01;
    localparam logic [7:0] TYPE_ID_RSP    = 8'h02;
    localparam logic [7:0] TYPE_LINK_UP   = 8'h03;
    localparam logic [7:0] TYPE_LINK_DOWN = 8'h04;
    localparam logic [7:0] TYPE_FROM_APS  = 8'h05;
    localparam logic [7:0] TYPE_FROM_APC  = 8'h06;
    localparam logic [7:0] TYPE_VENDOR    = 8'h7F;

    localparam logic [2:0] MTYPE_NOP    = 3'd0;
    localparam logic [2:0] MTYPE_VENDOR = 3'd7;

    typedef enum logic [1:0] {
        EV_HEADER  = 2'd0,
        EV_PAYLOAD = 2'd1,
        EV_REJECT  = 2'd2,
        EV_HALTED  = 2'd3
    } t_event;

    typedef struct packed {
        t_event      event_res;
        logic        message_done;
        logic [2:0]  msg_type;
        logic [47:0] address;
        logic [15:0] msg_length;
        logic [7:0]  payload_byte;
        logic [15:0] payload_index;
        logic        error_flag;
    } t_result;

    // Fold the raw type byte into the 3-bit reported type; unknown codes report as nop.
    function automatic logic [2:0] map_type(input logic [7:0] raw);
        logic [2:0] mt;
        if (raw <= TYPE_FROM_APC) begin
            mt = raw[2:0];
        end else if (raw == TYPE_VENDOR) begin
            mt = MTYPE_VENDOR;
        end else begin
            mt = MTYPE_NOP;
        end
        return mt;
    endfunction

endpackage

[src/adf_in_if.sv]
// Input item channel of the deframer: one stream byte per item.
// Valid/ready handshake; no package dependency.
interface adf_in_if ();
    logic       valid;
    logic       ready;
    logic [7:0] octet;

    modport source (output valid, output octet, input ready);
    modport sink   (input valid, input octet, output ready);
endinterface

[src/adf_out_if.sv]
// Result item channel of the deframer: one t_result per accepted byte.
// Depends on adf_pkg for the result type.
interface adf_out_if import adf_pkg::*; ();
    logic    valid;
    logic    ready;
    t_result data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[src/appdu_stream_deframer.sv]
// Application message deframer: header collection, header checks and payload streaming.
// Depends on adf_pkg, adf_in_if and adf_out_if.
//
// Usage:
//   i_in carries one stream byte per item (valid/ready). o_out carries exactly one
//   result item per accepted byte: event code, done flag, mapped type, header
//   address and length, payload byte and index, and the sticky error flag.
//   i_cfg_we/i_cfg_wdata write the maximum payload length for the payload
//   carrying types; write it only while no item is in flight.
// Latency and throughput:
//   A byte's result item is loaded into the result register when the byte is
//   accepted and shows from the next cycle on. One byte per cycle is sustained
//   while the receiver takes results: the header check and counter update fit
//   in a single combinational pass in front of the result register.
// Reset (synchronous, active low):
//   Clears all header registers, counters and the error flag, empties the
//   result register and loads a maximum payload length of 1500.
// Receiver stall:
//   The result register holds its item; i_in.ready stays high only while the
//   held item is being taken in the same cycle, so at most one item waits.
// After a rejected header every later byte reports the halted event (EV_HALTED) until reset.
module appdu_stream_deframer
    import adf_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_we,
    input  logic [15:0]  i_cfg_wdata,
    adf_in_if.sink       i_in,
    adf_out_if.source    o_out
);

    logic [15:0]          r_max_len;
    logic [HDR_CNT_W-1:0] r_hdr_cnt,   n_hdr_cnt;
    logic [7:0]           r_version,   n_version;
    logic [7:0]           r_type,      n_type;
    logic [15:0]          r_length,    n_length;
    logic [47:0]          r_address,   n_address;
    logic [15:0]          r_reserved,  n_reserved;
    logic [15:0]          r_bytes_left, n_bytes_left;
    logic [15:0]          r_pos,       n_pos;
    logic                 r_halted,    n_halted;
    logic                 r_valid;
    t_result              r_res,       n_res;

    logic [HDR_CNT_W-1:0] hdr_slot;
    logic                 hdr_ok;
    logic                 has_payload;
    logic                 accept;

    assign i_in.ready  = !r_valid || o_out.ready;
    assign accept      = i_in.valid && i_in.ready;
    assign o_out.valid = r_valid;
    assign o_out.data  = r_res;

    always_comb begin
        n_hdr_cnt    = r_hdr_cnt;
        n_version    = r_version;
        n_type       = r_type;
        n_length     = r_length;
        n_address    = r_address;
        n_reserved   = r_reserved;
        n_bytes_left = r_bytes_left;
        n_pos        = r_pos;
        n_halted     = r_halted;
        hdr_slot     = '0;
        hdr_ok       = 1'b0;
        has_payload  = 1'b0;

        n_res              = '0;
        n_res.event_res    = EV_HEADER;

        if (r_halted) begin
            n_res.event_res = EV_HALTED;
        end else if (r_hdr_cnt < HDR_CNT_W'(HDR_BYTES) || r_bytes_left == '0) begin
            // restart collection if the counter sits past a finished header
            hdr_slot = (r_hdr_cnt >= HDR_CNT_W'(HDR_BYTES)) ? '0 : r_hdr_cnt;
            case (hdr_slot)
                4'd0:    n_version           = i_in.octet;
                4'd1:    n_type              = i_in.octet;
                4'd2:    n_length[15:8]      = i_in.octet;
                4'd3:    n_length[7:0]       = i_in.octet;
                4'd4:    n_address[47:40]    = i_in.octet;
                4'd5:    n_address[39:32]    = i_in.octet;
                4'd6:    n_address[31:24]    = i_in.octet;
                4'd7:    n_address[23:16]    = i_in.octet;
                4'd8:    n_address[15:8]     = i_in.octet;
                4'd9:    n_address[7:0]      = i_in.octet;
                4'd10:   n_reserved[15:8]    = i_in.octet;
                default: n_reserved[7:0]     = i_in.octet;
            endcase
            n_hdr_cnt = hdr_slot + 1'b1;

            if (n_hdr_cnt == HDR_CNT_W'(HDR_BYTES)) begin
                case (n_type)
                    TYPE_NOP: begin
                        hdr_ok = (n_length == '0) && (n_address == '0);
                    end
                    TYPE_ID_REQ, TYPE_ID_RSP: begin
                        hdr_ok      = (n_length == ID_PAYLOAD_LEN);
                        has_payload = 1'b1;
                    end
                    TYPE_LINK_UP, TYPE_LINK_DOWN: begin
                        hdr_ok = (n_length == '0);
                    end
                    TYPE_FROM_APS, TYPE_FROM_APC, TYPE_VENDOR: begin
                        hdr_ok      = (n_length <= r_max_len);
                        has_payload = (n_length != '0);
                    end
                    default: hdr_ok = 1'b0;
                endcase
                if (n_version != APPDU_VERSION || n_reserved != '0) begin
                    hdr_ok = 1'b0;
                end

                if (!hdr_ok) begin
                    n_halted        = 1'b1;
                    n_res.event_res = EV_REJECT;
                end else if (!has_payload) begin
                    n_res.message_done = 1'b1;
                    n_hdr_cnt          = '0;
                    n_bytes_left       = '0;
                end else begin
                    n_bytes_left = n_length;
                    n_pos        = '0;
                end
            end
        end else begin
            n_res.event_res     = EV_PAYLOAD;
            n_res.payload_byte  = i_in.octet;
            n_res.payload_index = r_pos;
            n_pos               = r_pos + 16'd1;
            n_bytes_left        = r_bytes_left - 16'd1;
            if (n_bytes_left == '0) begin
                n_res.message_done = 1'b1;
                n_hdr_cnt          = '0;
            end
        end

        n_res.msg_type       = map_type(n_type);
        n_res.address        = n_address;
        n_res.msg_length     = n_length;
        n_res.error_flag     = n_halted;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_len    <= MAX_LEN_DEFAULT;
            r_hdr_cnt    <= '0;
            r_version    <= '0;
            r_type       <= '0;
            r_length     <= '0;
            r_address    <= '0;
            r_reserved   <= '0;
            r_bytes_left <= '0;
            r_pos        <= '0;
            r_halted     <= 1'b0;
            r_valid      <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_max_len <= i_cfg_wdata;
            end
            if (accept) begin
                r_hdr_cnt    <= n_hdr_cnt;
                r_version    <= n_version;
                r_type       <= n_type;
                r_length     <= n_length;
                r_address    <= n_address;
                r_reserved   <= n_reserved;
                r_bytes_left <= n_bytes_left;
                r_pos        <= n_pos;
                r_halted     <= n_halted;
                r_valid      <= 1'b1;
            end else if (o_out.ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    // result payload: loaded on accept, held otherwise
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_res <= n_res;
        end
    end

    a_halt_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_halted |=> r_halted)
        else $error("error flag cleared without reset");

    a_payload_needs_header: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_bytes_left != '0) |-> (r_hdr_cnt == HDR_CNT_W'(HDR_BYTES)))
        else $error("payload due while header incomplete");

    a_halted_ignores: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && r_halted) |=> (r_valid && r_res.event_res == EV_HALTED))
        else $error("byte not ignored while halted");

    a_done_event: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_res.message_done) |->
            (r_res.event_res == EV_HEADER || r_res.event_res == EV_PAYLOAD))
        else $error("message done on reject or ignored byte");

    a_payload_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_res.event_res == EV_PAYLOAD) |-> !r_res.error_flag)
        else $error("payload item with error flag set");

endmodule

[tb/sv/tb_top.sv]
// Self-checking bench for appdu_stream_deframer: sends framed byte streams of every message type
// under random gaps and stalls, predicts each result item and compares field by field.
// Depends on adf_pkg, adf_in_if, adf_out_if and the deframer RTL.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import adf_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 400_000;

    typedef enum {HDR_BAD, HDR_NO_PAYLOAD, HDR_PAYLOAD} t_verdict;
    typedef enum {
        BAD_VERSION, BAD_RESERVED, NOP_LENGTH, NOP_ADDRESS,
        ID_LENGTH, LINK_LENGTH, OVER_MAX, UNKNOWN_TYPE
    } t_fault;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [15:0] i_cfg_wdata;

    adf_in_if  in_if ();
    adf_out_if out_if ();

    appdu_stream_deframer DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in        (in_if),
        .o_out       (out_if)
    );

    // deframer state as the bench expects it
    logic [15:0] max_len_cfg = MAX_LEN_DEFAULT;
    logic [3:0]  hdr_cnt     = '0;
    logic [7:0]  hdr_ver     = '0;
    logic [7:0]  hdr_type    = '0;
    logic [15:0] hdr_len     = '0;
    logic [47:0] hdr_addr    = '0;
    logic [15:0] hdr_rsvd    = '0;
    logic [15:0] pl_left     = '0;
    logic [15:0] pl_pos      = '0;
    logic        halted_m    = 1'b0;

    logic [7:0]  octet_q[$];
    t_result     result_due_q[$];
    int unsigned mismatch_count = 0;
    int unsigned cycles = 0;
    logic        byte_taken = 1'b0;
    int          src_gap = 0;
    int          src_burst = 0;
    int          sink_stall = 0;
    int          sink_burst = 0;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    task automatic deframe_byte(input logic [7:0] b, output t_result r);
        t_verdict v;
        r = '0;
        r.event_res = EV_HEADER;
        if (halted_m) begin
            r.event_res = EV_HALTED;
        end else if (hdr_cnt < HDR_BYTES || pl_left == 0) begin
            if (hdr_cnt >= HDR_BYTES) begin
                hdr_cnt = '0;
            end
            case (hdr_cnt)
                4'd0:    hdr_ver = b;
                4'd1:    hdr_type = b;
                4'd2:    hdr_len[15:8] = b;
                4'd3:    hdr_len[7:0] = b;
                4'd10:   hdr_rsvd[15:8] = b;
                4'd11:   hdr_rsvd[7:0] = b;
                default: hdr_addr[8 * (9 - hdr_cnt) +: 8] = b;
            endcase
            hdr_cnt = hdr_cnt + 1'b1;
            if (hdr_cnt == HDR_BYTES) begin
                if (hdr_ver != APPDU_VERSION || hdr_rsvd != 0) begin
                    v = HDR_BAD;
                end else begin
                    case (hdr_type)
                        TYPE_NOP:
                            v = (hdr_len == 0 && hdr_addr == 0) ? HDR_NO_PAYLOAD : HDR_BAD;
                        TYPE_ID_REQ, TYPE_ID_RSP:
                            v = (hdr_len == ID_PAYLOAD_LEN) ? HDR_PAYLOAD : HDR_BAD;
                        TYPE_LINK_UP, TYPE_LINK_DOWN:
                            v = (hdr_len == 0) ? HDR_NO_PAYLOAD : HDR_BAD;
                        TYPE_FROM_APS, TYPE_FROM_APC, TYPE_VENDOR: begin
                            if (hdr_len > max_len_cfg) v = HDR_BAD;
                            else if (hdr_len == 0) v = HDR_NO_PAYLOAD;
                            else v = HDR_PAYLOAD;
                        end
                        default: v = HDR_BAD;
                    endcase
                end
                case (v)
                    HDR_BAD: begin
                        halted_m = 1'b1;
                        r.event_res = EV_REJECT;
                    end
                    HDR_NO_PAYLOAD: begin
                        r.message_done = 1'b1;
                        hdr_cnt = '0;
                        pl_left = '0;
                    end
                    default: begin
                        pl_left = hdr_len;
                        pl_pos = '0;
                    end
                endcase
            end
        end else begin
            r.event_res = EV_PAYLOAD;
            r.payload_byte = b;
            r.payload_index = pl_pos;
            pl_pos = pl_pos + 1'b1;
            pl_left = pl_left - 1'b1;
            if (pl_left == 0) begin
                r.message_done = 1'b1;
                hdr_cnt = '0;
            end
        end
        case (hdr_type)
            TYPE_NOP, TYPE_ID_REQ, TYPE_ID_RSP, TYPE_LINK_UP, TYPE_LINK_DOWN,
            TYPE_FROM_APS, TYPE_FROM_APC: r.msg_type = hdr_type[2:0];
            TYPE_VENDOR: r.msg_type = MTYPE_VENDOR;
            default:     r.msg_type = MTYPE_NOP;
        endcase
        r.address = hdr_addr;
        r.msg_length = hdr_len;
        r.error_flag = halted_m;
    endtask

    task automatic report_field(input string field, input logic [47:0] want,
                                input logic [47:0] got);
        if (want !== got) begin
            mismatch_count++;
            $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
        end
    endtask

    // Mostly short gaps, a few long ones, and now and then a burst with none.
    function automatic int idle_len(inout int burst);
        int unsigned r;
        if (burst > 0) begin
            burst--;
            return 0;
        end
        if ($urandom_range(0, 49) == 0) begin
            burst = $urandom_range(20, 100);
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [47:0] rand_addr();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            default: return {16'($urandom()), $urandom()};
        endcase
    endfunction

    task automatic push_message(input logic [7:0] ver, input logic [7:0] typ,
                                input logic [15:0] len, input logic [47:0] addr,
                                input logic [15:0] rsvd, input int unsigned body);
        octet_q.push_back(ver);
        octet_q.push_back(typ);
        octet_q.push_back(len[15:8]);
        octet_q.push_back(len[7:0]);
        for (int i = 5; i >= 0; i--) begin
            octet_q.push_back(addr[8 * i +: 8]);
        end
        octet_q.push_back(rsvd[15:8]);
        octet_q.push_back(rsvd[7:0]);
        repeat (body) octet_q.push_back(8'($urandom()));
    endtask

    task automatic push_random_message(output int unsigned n);
        logic [7:0]  typ;
        logic [15:0] len;
        logic [47:0] addr;
        int unsigned lim;
        int unsigned body;
        addr = rand_addr();
        len = '0;
        body = 0;
        case ($urandom_range(0, 7))
            0: begin
                typ = TYPE_NOP;
                addr = '0;
            end
            1:       typ = TYPE_ID_REQ;
            2:       typ = TYPE_ID_RSP;
            3:       typ = TYPE_LINK_UP;
            4:       typ = TYPE_LINK_DOWN;
            5:       typ = TYPE_FROM_APS;
            6:       typ = TYPE_FROM_APC;
            default: typ = TYPE_VENDOR;
        endcase
        if (typ == TYPE_ID_REQ || typ == TYPE_ID_RSP) begin
            len = ID_PAYLOAD_LEN;
            body = 32'(len);
        end else if (typ == TYPE_FROM_APS || typ == TYPE_FROM_APC || typ == TYPE_VENDOR) begin
            lim = 32'(max_len_cfg);
            // rarely the maximum if it is at most 64, else up to 300; mostly short bodies
            case ($urandom_range(0, 19))
                0:       len = 16'((lim <= 64) ? lim
                                   : $urandom_range(65, (lim < 300) ? lim : 300));
                1:       len = '0;
                default: len = 16'((lim == 0) ? 0 : $urandom_range(1, (lim < 24) ? lim : 24));
            endcase
            body = 32'(len);
        end
        push_message(APPDU_VERSION, typ, len, addr, 16'h0, body);
        n = HDR_BYTES + body;
    endtask

    task automatic random_phase(input int unsigned budget);
        int unsigned sent;
        int unsigned n;
        sent = 0;
        while (sent < budget) begin
            push_random_message(n);
            sent += n;
        end
    endtask

    // Sample at the rising edge, where neither the queue nor the source valid moves,
    // then return on the following falling edge.
    task automatic wait_idle();
        do @(posedge i_clk);
        while (octet_q.size() != 0 || in_if.valid || result_due_q.size() != 0);
        @(negedge i_clk);
    endtask

    task automatic write_max_len(input logic [15:0] value);
        wait_idle();
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= value;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        max_len_cfg = value;
    endtask

    // byte source
    always @(negedge i_clk) begin : byte_driver
        if (!i_rst_n) begin
            in_if.valid <= 1'b0;
        end else if (in_if.valid && !byte_taken) begin
            // hold the byte until it is taken
        end else if (src_gap > 0) begin
            in_if.valid <= 1'b0;
            src_gap--;
        end else if (octet_q.size() != 0) begin
            in_if.valid <= 1'b1;
            in_if.octet <= octet_q.pop_front();
            src_gap = idle_len(src_burst);
        end else begin
            in_if.valid <= 1'b0;
        end
    end

    // result sink with random back-pressure
    always @(negedge i_clk) begin : result_sink
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
        end else if (sink_stall > 0) begin
            out_if.ready <= 1'b0;
            sink_stall--;
        end else begin
            out_if.ready <= 1'b1;
            sink_stall = idle_len(sink_burst);
        end
    end

    always @(posedge i_clk) begin : monitor
        t_result got;
        t_result want;
        if (out_if.valid && out_if.ready) begin
            got = out_if.data;
            if (result_due_q.size() == 0) begin
                mismatch_count++;
                $display("%0t ns: result with nothing expected, actual %0h", $time, got);
            end else begin
                want = result_due_q.pop_front();
                report_field("event_res", 48'(want.event_res), 48'(got.event_res));
                report_field("message_done", 48'(want.message_done), 48'(got.message_done));
                report_field("msg_type", 48'(want.msg_type), 48'(got.msg_type));
                report_field("address", want.address, got.address);
                report_field("msg_length", 48'(want.msg_length), 48'(got.msg_length));
                report_field("payload_byte", 48'(want.payload_byte), 48'(got.payload_byte));
                report_field("payload_index", 48'(want.payload_index),
                             48'(got.payload_index));
                report_field("error_flag", 48'(want.error_flag), 48'(got.error_flag));
            end
        end
        byte_taken = i_rst_n && in_if.valid && in_if.ready;
        if (byte_taken) begin
            deframe_byte(in_if.octet, want);
            result_due_q.push_back(want);
        end
    end

    always @(posedge i_clk) begin : watchdog
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    initial begin : stimulus
        t_fault      fault;
        logic [7:0]  ver;
        logic [7:0]  typ;
        logic [15:0] len;
        logic [47:0] addr;
        logic [15:0] rsvd;
        int unsigned pick;

        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_wdata = '0;
        in_if.valid = 1'b0;
        in_if.octet = '0;
        out_if.ready = 1'b0;
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // one message of each type at the reset maximum
        push_message(APPDU_VERSION, TYPE_NOP, 16'd0, 48'h0, 16'h0, 0);
        push_message(APPDU_VERSION, TYPE_ID_REQ, ID_PAYLOAD_LEN, '1, 16'h0,
                     32'(ID_PAYLOAD_LEN));
        push_message(APPDU_VERSION, TYPE_ID_RSP, ID_PAYLOAD_LEN, rand_addr(), 16'h0,
                     32'(ID_PAYLOAD_LEN));
        push_message(APPDU_VERSION, TYPE_LINK_UP, 16'd0, rand_addr(), 16'h0, 0);
        push_message(APPDU_VERSION, TYPE_LINK_DOWN, 16'd0, 48'h0, 16'h0, 0);
        push_message(APPDU_VERSION, TYPE_FROM_APS, 16'd2, rand_addr(), 16'h0, 0);
        octet_q.push_back(8'h00);
        octet_q.push_back(8'hFF);
        // payload type with no payload completes on the last header byte
        push_message(APPDU_VERSION, TYPE_FROM_APC, 16'd0, rand_addr(), 16'h0, 0);
        push_message(APPDU_VERSION, TYPE_VENDOR, 16'd3, rand_addr(), 16'h0, 3);

        write_max_len(16'd0);
        random_phase(90);
        write_max_len(16'hFFFF);
        random_phase(130);
        write_max_len(16'($urandom_range(1, 40)));
        random_phase(140);
        write_max_len(MAX_LEN_DEFAULT);
        random_phase(100);

        // one broken header halts the deframer for the rest of the run
        ver = APPDU_VERSION;
        typ = TYPE_LINK_UP;
        len = '0;
        addr = rand_addr();
        rsvd = '0;
        fault = t_fault'($urandom_range(0, 7));
        case (fault)
            BAD_VERSION: ver = 8'($urandom_range(1, 255));
            BAD_RESERVED: begin
                typ = TYPE_ID_REQ;
                len = ID_PAYLOAD_LEN;
                rsvd = 16'($urandom_range(1, 65535));
            end
            NOP_LENGTH: begin
                typ = TYPE_NOP;
                addr = '0;
                len = 16'($urandom_range(1, 65535));
            end
            NOP_ADDRESS: begin
                typ = TYPE_NOP;
                addr[$urandom_range(0, 47)] = 1'b1;
            end
            ID_LENGTH: begin
                typ = $urandom_range(0, 1) ? TYPE_ID_REQ : TYPE_ID_RSP;
                len = 16'($urandom());
                if (len == ID_PAYLOAD_LEN) len = 16'hFFFF;
            end
            LINK_LENGTH: begin
                typ = $urandom_range(0, 1) ? TYPE_LINK_UP : TYPE_LINK_DOWN;
                len = 16'($urandom_range(1, 65535));
            end
            OVER_MAX: begin
                case ($urandom_range(0, 2))
                    0:       typ = TYPE_FROM_APS;
                    1:       typ = TYPE_FROM_APC;
                    default: typ = TYPE_VENDOR;
                endcase
                len = 16'($urandom_range(max_len_cfg + 1, 65535));
            end
            default: begin
                // skip the eight known codes
                pick = $urandom_range(0, 247);
                typ = (pick < 120) ? 8'(pick + 7) : 8'(pick - 120 + 8'h80);
                len = 16'($urandom());
            end
        endcase
        push_message(ver, typ, len, addr, rsvd, 0);
        repeat ($urandom_range(16, 40)) octet_q.push_back(8'($urandom()));

        wait_idle();
        repeat (8) @(negedge i_clk);
        if (mismatch_count == 0 && result_due_q.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
